// ===== hdl/flmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// flmpc_pkg
// Register indexes, reset values and field widths of the fluid level monitor.
// ----------------------------------------------------------------------------
package flmpc_pkg;

  localparam int LEVEL_W = 16;
  localparam int RATE_W  = 18;
  localparam int TOTAL_W = 22;
  localparam int OVF_W   = 8;
  localparam int CFG_W   = 16;
  localparam int MULT_W  = 4;
  localparam int POS_W   = 8;
  localparam int CFG_IDX_W = 3;

  // out_tdata layout, lowest bit up
  localparam int LEVEL_LSB = 0;
  localparam int RATE_LSB  = LEVEL_LSB + LEVEL_W;
  localparam int TOTAL_LSB = RATE_LSB + RATE_W;
  localparam int DRAIN_BIT = TOTAL_LSB + TOTAL_W;
  localparam int FILL_BIT  = DRAIN_BIT + 1;
  localparam int OVF_LSB   = FILL_BIT + 1;
  localparam int OUT_USED  = OVF_LSB + OVF_W;
  localparam int OUT_DATA_W = ((OUT_USED + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]  SLOPE_RST    = 16'd17315;
  localparam logic [CFG_W-1:0]  OFFSET_RST   = 16'd9844;
  localparam logic [CFG_W-1:0]  HI_TH_RST    = 16'd7680;
  localparam logic [CFG_W-1:0]  LO_TH_RST    = 16'd1024;
  localparam logic [CFG_W-1:0]  OVF_VOL_RST  = 16'd6656;
  localparam logic [MULT_W-1:0] MULT_RST     = 4'd4;

  localparam logic [OVF_W-1:0]  OVF_MAX  = 8'd255;
  localparam logic [RATE_W-1:0] RATE_MAX = 18'd262143;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE   = 3'd0,
    CFG_OFFSET  = 3'd1,
    CFG_HI_TH   = 3'd2,
    CFG_LO_TH   = 3'd3,
    CFG_OVF_VOL = 3'd4,
    CFG_MULT    = 3'd5
  } cfg_idx_t;

endpackage

// ===== hdl/fluid_level_monitor_pump_control_core.sv =====
// ----------------------------------------------------------------------------
// fluid_level_monitor_pump_control_core
// Level estimate, hourly rate, total volume and drain/fill pump hysteresis.
// ----------------------------------------------------------------------------
// Usage:
// in channel: in_tuser selects the item kind (0 camera sample, 1 timer tick),
// in_tdata carries the surface pixel row. Every accepted item gives exactly
// one result on the out channel: level, hourly rate, total volume, pump
// drives and overflow count in out_tdata, out_tlast set when the sample
// closed a block of BLOCK_LEN samples, out_tuser set once a rate was taken.
// One item per cycle sustained while out_tready is high; an accepted item
// passes the entry stage, then the result register. The slope * position
// product is formed as the item enters, the block update, reciprocal divide
// and hysteresis then settle into the result register.
// cfg_we writes a register by index; the user does so only while the block is idle,
// the block does not enforce it. A slope or overflow volume write also rescales
// the running product accumulators. Reset (rst_n low, synchronous) loads the default
// calibration and clears all state, pumps off. When out_tready is low the result
// holds, one more item may be taken into the entry stage, then in_tready drops.
// ----------------------------------------------------------------------------
module fluid_level_monitor_pump_control_core
  import flmpc_pkg::*;
#(
  parameter int BLOCK_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [POS_W-1:0]      in_tdata,   // y_position
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // level, hourly_rate, total_volume, drain_pump, fill_pump, overflow_count, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // report
  output logic                  out_tuser,  // rate_valid
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CNT_W  = $clog2(BLOCK_LEN + 1);
  localparam int SUM_W  = $clog2(BLOCK_LEN * 255 + 1);
  localparam int PROD_W = CFG_W + POS_W;
  localparam int ACC_W  = CFG_W + SUM_W;
  localparam int X_W    = ACC_W - 8;
  localparam int RECIP_SH = X_W + $clog2(BLOCK_LEN);
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int RECIP_W = X_W + 1;
  localparam int LV_W   = X_W + 2;
  localparam int TOT_W  = 2 * CFG_W + OVF_W - CFG_W + 2;  // 26 bits
  localparam int OVP_W  = CFG_W + OVF_W;
  localparam int R_W    = LEVEL_W + 1 + 5;

  localparam logic [RECIP_W-1:0]    RECIP_C = RECIP_W'(RECIP);
  localparam logic [CNT_W-1:0]      CNT_END = CNT_W'(BLOCK_LEN);
  localparam logic signed [LV_W-1:0]  LV_HI  = LV_W'(32'sd32767);
  localparam logic signed [LV_W-1:0]  LV_LO  = LV_W'(-32'sd32768);
  localparam logic signed [TOT_W-1:0] TOT_HI = TOT_W'(32'sd2097151);
  localparam logic signed [TOT_W-1:0] TOT_LO = TOT_W'(-32'sd2097152);

  // configuration registers
  logic [CFG_W-1:0]  slope_r, offset_r, hi_th_r, lo_th_r, ovf_vol_r;
  logic [MULT_W-1:0] mult_r;

  // entry stage
  logic              s1_valid_r;
  logic              s1_func_r;
  logic [POS_W-1:0]  s1_y_r;
  logic [PROD_W-1:0] s1_prod_r;

  // block state
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [LEVEL_W-1:0] level_r, level_nxt, prev_r, prev_nxt;
  logic [RATE_W-1:0]         rate_r, rate_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic [OVF_W-1:0]          ovf_r, ovf_nxt;
  logic [OVP_W-1:0]          ovf_prod_r, ovf_prod_nxt;
  logic                      draining_r, draining_nxt;
  logic                      fill_r, fill_nxt;
  logic                      have_rd_r, have_rd_nxt;
  logic                      have_rate_r, have_rate_nxt;

  // result register
  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] o_level_r;
  logic [RATE_W-1:0]         o_rate_r;
  logic signed [TOTAL_W-1:0] o_total_r;
  logic                      o_drain_r, o_fill_r, o_report_r, o_rvalid_r;
  logic [OVF_W-1:0]          o_ovf_r;

  logic adv, fire, in_acc;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // block arithmetic
  logic [SUM_W-1:0]            sum_add;
  logic [ACC_W-1:0]            acc_add;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        blk_end;
  logic [X_W-1:0]              x_div;
  logic [X_W+RECIP_W-1:0]      q_full;
  logic [X_W-1:0]              q_div;
  logic signed [LV_W-1:0]      lv_full;
  logic signed [LEVEL_W-1:0]   lvl_blk, level_cur;
  logic signed [TOT_W-1:0]     tot_full;
  logic signed [TOTAL_W-1:0]   tot_sat;
  logic signed [LEVEL_W:0]     diff;
  logic signed [R_W-1:0]       r_full;
  logic                        hi_hit, lo_hit;

  always_comb begin
    sum_add = sum_r + SUM_W'(s1_y_r);
    acc_add = acc_r + ACC_W'(s1_prod_r);
    cnt_inc = cnt_r + CNT_W'(1);
    blk_end = !s1_func_r && (cnt_inc == CNT_END);

    // floor(acc / (BLOCK_LEN * 256)) as a shift then an exact reciprocal multiply
    x_div   = acc_add[ACC_W-1:8];
    q_full  = (X_W+RECIP_W)'(x_div) * (X_W+RECIP_W)'(RECIP_C);
    q_div   = X_W'(q_full >> RECIP_SH);
    lv_full = LV_W'(signed'(offset_r)) - $signed({2'b00, q_div});
    if (lv_full > LV_HI) begin
      lvl_blk = 16'sh7fff;
    end else if (lv_full < LV_LO) begin
      lvl_blk = -16'sh8000;
    end else begin
      lvl_blk = LEVEL_W'(lv_full);
    end

    tot_full = TOT_W'(lvl_blk) + $signed({2'b00, ovf_prod_r});
    if (tot_full > TOT_HI) begin
      tot_sat = 22'sh1fffff;
    end else if (tot_full < TOT_LO) begin
      tot_sat = -22'sh200000;
    end else begin
      tot_sat = TOTAL_W'(tot_full);
    end

    diff   = (LEVEL_W+1)'(level_r) - (LEVEL_W+1)'(prev_r);
    r_full = R_W'(diff) * $signed({(R_W-MULT_W)'(0), mult_r});

    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    level_nxt     = level_r;
    prev_nxt      = prev_r;
    rate_nxt      = rate_r;
    total_nxt     = total_r;
    have_rd_nxt   = have_rd_r;
    have_rate_nxt = have_rate_r;

    if (!s1_func_r) begin
      if (blk_end) begin
        sum_nxt   = '0;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        level_nxt = lvl_blk;
        if (!have_rd_r && !draining_r) begin
          have_rd_nxt = 1'b1;
          prev_nxt    = lvl_blk;
        end
        if (!draining_r) begin
          total_nxt = tot_sat;
        end
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
        acc_nxt = acc_add;
      end
    end else begin
      if (!draining_r && have_rd_r && !r_full[R_W-1]) begin
        rate_nxt      = (r_full > $signed(R_W'(RATE_MAX))) ? RATE_MAX : RATE_W'(r_full);
        prev_nxt      = level_r;
        have_rate_nxt = 1'b1;
      end
      if (draining_r) begin
        have_rd_nxt = 1'b0;
      end
    end

    // hysteresis: high rule first, low rule may override
    level_cur    = level_nxt;
    hi_hit       = (level_cur >= signed'(hi_th_r)) && !draining_r;
    lo_hit       = level_cur < signed'(lo_th_r);
    draining_nxt = draining_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    ovf_prod_nxt = ovf_prod_r;
    if (hi_hit) begin
      draining_nxt = 1'b1;
      fill_nxt     = 1'b0;
      if (ovf_r != OVF_MAX) begin
        ovf_nxt      = ovf_r + OVF_W'(1);
        ovf_prod_nxt = ovf_prod_r + OVP_W'(ovf_vol_r);
      end
    end
    if (lo_hit) begin
      draining_nxt = 1'b0;
      fill_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r     <= SLOPE_RST;
      offset_r    <= OFFSET_RST;
      hi_th_r     <= HI_TH_RST;
      lo_th_r     <= LO_TH_RST;
      ovf_vol_r   <= OVF_VOL_RST;
      mult_r      <= MULT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      level_r     <= '0;
      prev_r      <= '0;
      rate_r      <= '0;
      total_r     <= '0;
      ovf_r       <= '0;
      ovf_prod_r  <= '0;
      draining_r  <= 1'b0;
      fill_r      <= 1'b0;
      have_rd_r   <= 1'b0;
      have_rate_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
        acc_r       <= acc_nxt;
        level_r     <= level_nxt;
        prev_r      <= prev_nxt;
        rate_r      <= rate_nxt;
        total_r     <= total_nxt;
        ovf_r       <= ovf_nxt;
        ovf_prod_r  <= ovf_prod_nxt;
        draining_r  <= draining_nxt;
        fill_r      <= fill_nxt;
        have_rd_r   <= have_rd_nxt;
        have_rate_r <= have_rate_nxt;
      end

      // a rescaling write keeps the running products consistent
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SLOPE: begin
            slope_r <= cfg_wdata;
            acc_r   <= ACC_W'(cfg_wdata) * ACC_W'(sum_r);
          end
          CFG_OFFSET: offset_r <= cfg_wdata;
          CFG_HI_TH:  hi_th_r  <= cfg_wdata;
          CFG_LO_TH:  lo_th_r  <= cfg_wdata;
          CFG_OVF_VOL: begin
            ovf_vol_r  <= cfg_wdata;
            ovf_prod_r <= OVP_W'(cfg_wdata) * OVP_W'(ovf_r);
          end
          CFG_MULT:   mult_r   <= cfg_wdata[MULT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_tuser;
      s1_y_r    <= in_tdata;
      s1_prod_r <= PROD_W'(slope_r) * PROD_W'(in_tdata);
    end
    if (fire) begin
      o_level_r  <= level_nxt;
      o_rate_r   <= rate_nxt;
      o_total_r  <= total_nxt;
      o_drain_r  <= draining_nxt;  // drain pump runs exactly while draining
      o_fill_r   <= fill_nxt;
      o_ovf_r    <= ovf_nxt;
      o_report_r <= blk_end;
      o_rvalid_r <= have_rate_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_report_r;
  assign out_tuser  = o_rvalid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_USED)'(0), o_ovf_r, o_fill_r, o_drain_r,
                       o_total_r, o_rate_r, o_level_r};

  a_pumps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(draining_r && fill_r))
    else $error("drain and fill pumps both on");

  a_count_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_END)
    else $error("sample count reached block length");

  a_rate_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (rate_r != '0) |-> have_rate_r)
    else $error("rate held without rate flag");

  a_result_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item consumed without result");

endmodule
